// ----- sv/assert_macros.svh -----
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication under clk_i, off during reset
`define ASSERT_IMPL(lbl, ant, con) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (con)) \
    else $error("assertion failed");

// next-cycle implication under clk_i, off during reset
`define ASSERT_NEXT(lbl, ant, con) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (con)) \
    else $error("assertion failed");

`endif

// ----- sv/alc_pkg.sv -----
// types, token codes and keyword table of the assembly line token classifier
`default_nettype none

package alc_pkg;

  localparam int MAX_LINE_DEF      = 256;
  localparam int KEYWORD_CHARS_DEF = 6;

  // token kind codes
  localparam logic [3:0] K_UNKNOWN  = 4'd0;
  localparam logic [3:0] K_PREFIX   = 4'd1;
  localparam logic [3:0] K_MNEMONIC = 4'd2;
  localparam logic [3:0] K_REGISTER = 4'd3;
  localparam logic [3:0] K_COMMA    = 4'd4;
  localparam logic [3:0] K_MEMSIZE  = 4'd5;
  localparam logic [3:0] K_PTR      = 4'd6;
  localparam logic [3:0] K_SEGMENT  = 4'd7;
  localparam logic [3:0] K_OPEN     = 4'd8;
  localparam logic [3:0] K_CLOSE    = 4'd9;
  localparam logic [3:0] K_COLON    = 4'd10;
  localparam logic [3:0] K_PLUS     = 4'd11;
  localparam logic [3:0] K_MINUS    = 4'd12;
  localparam logic [3:0] K_MULT     = 4'd13;
  localparam logic [3:0] K_LINE_END = 4'd14;

  // queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  typedef struct packed {
    logic [3:0] kind;
    logic [7:0] pos;
    logic [7:0] len;
  } res_t;

  // one queue entry: the results caused by one item
  typedef struct packed {
    logic two;
    logic last;
    res_t r0;
    res_t r1;
  } entry_t;

  // queue status seen by the top level
  typedef struct packed {
    logic full;
    logic valid;
  } qstat_t;

  // keyword table, byte i of the text in bits 8i+7..8i, unused bytes zero
  localparam int NUM_KW   = 23;
  localparam int KW_BYTES = 5;

  localparam logic [8*KW_BYTES-1:0] KW_TEXT [NUM_KW] = '{
    40'h0000007366, 40'h0000007364, 40'h0000007367, 40'h0000007365,
    40'h0000007373, 40'h0000007363,
    40'h0065747962, 40'h0064726f77, 40'h64726f7764, 40'h64726f7771,
    40'h0000786165, 40'h0000786265, 40'h0000786365, 40'h0000786465,
    40'h0000706265, 40'h0000707365, 40'h0000697365, 40'h0000696465,
    40'h006b636f6c, 40'h0000706572, 40'h656e706572, 40'h0065706572,
    40'h007a706572
  };

  localparam logic [7:0] KW_LEN [NUM_KW] = '{
    8'd2, 8'd2, 8'd2, 8'd2, 8'd2, 8'd2,
    8'd4, 8'd4, 8'd5, 8'd5,
    8'd3, 8'd3, 8'd3, 8'd3, 8'd3, 8'd3, 8'd3, 8'd3,
    8'd4, 8'd3, 8'd5, 8'd4, 8'd4
  };

  localparam logic [3:0] KW_KIND [NUM_KW] = '{
    K_SEGMENT, K_SEGMENT, K_SEGMENT, K_SEGMENT, K_SEGMENT, K_SEGMENT,
    K_MEMSIZE, K_MEMSIZE, K_MEMSIZE, K_MEMSIZE,
    K_REGISTER, K_REGISTER, K_REGISTER, K_REGISTER,
    K_REGISTER, K_REGISTER, K_REGISTER, K_REGISTER,
    K_PREFIX, K_PREFIX, K_PREFIX, K_PREFIX, K_PREFIX
  };

  localparam logic [8*KW_BYTES-1:0] PTR_TEXT = 40'h0000727470;
  localparam logic [7:0]            PTR_LEN  = 8'd3;

  // keyword lookup, returns {hit, kind}
  function automatic logic [4:0] kw_lookup(input logic [8*KW_BYTES-1:0] head,
                                           input logic [7:0] len);
    logic [4:0] r;
    r = 5'd0;
    for (int k = 0; k < NUM_KW; k++) begin
      if (len == KW_LEN[k] && head == KW_TEXT[k]) begin
        r = {1'b1, KW_KIND[k]};
      end
    end
    if (len == PTR_LEN && head == PTR_TEXT) begin
      r = {1'b1, K_PTR};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- sv/asm_line_token_classifier.sv -----
// top level of the assembly line token classifier
//
// input stream: one character per item in s_axis_tdata_i, s_axis_tlast_i on
// the line's final character. output stream: one token per item, tdata holds
// kind, start position and length, tlast marks the final token of a line.
// a word ends at space, tab, punctuation or line end; each of , : [ ] + - *
// gives its own one-character token after the word it ends. a line whose
// last character gives no token yields one line-end token of length zero.
// throughput: one character per cycle while the output is taken every cycle
// and each character gives at most one token; a character that gives two
// tokens shows them one after the other, set by the single output register.
// a token's tvalid rises once the back has loaded it: the front writes the
// four-entry queue at the accepting edge, and the back then loads the output
// register from the queue head while that register is free or being taken.
// s_axis_tready_o drops only when the queue is full, which happens once the
// receiver stalls long enough or two-token characters pile up.
// reset clears the line state, the queue and the output valid at once.
`default_nettype none
`include "assert_macros.svh"

module asm_line_token_classifier import alc_pkg::*; #(
  parameter int MAX_LINE      = MAX_LINE_DEF,
  parameter int KEYWORD_CHARS = KEYWORD_CHARS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] ch
  input  wire logic        s_axis_tlast_i,   // line_end
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [23:0]      m_axis_tdata_o,   // [3:0] token_kind, [11:4] start_pos,
                                             // [19:12] tok_len, [23:20] zero
  output logic             m_axis_tlast_o    // last_of_line
);

  entry_t entry, head;
  qstat_t qst;
  logic   accept, push, pop;
  res_t   res;

  assign s_axis_tready_o = !qst.full;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  // character front end
  alc_front #(
    .MAX_LINE      (MAX_LINE),
    .KEYWORD_CHARS (KEYWORD_CHARS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .ch_i       (s_axis_tdata_i),
    .line_end_i (s_axis_tlast_i),
    .entry_o    (entry),
    .push_o     (push)
  );

  // decoupling queue
  alc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .pop_i   (pop),
    .head_o  (head),
    .stat_o  (qst)
  );

  // token output
  alc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .head_valid_i (qst.valid),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_res_o    (res),
    .out_last_o   (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {4'd0, res.len, res.pos, res.kind};

  // two-result entries are always a word followed by a punctuation token
  `ASSERT_IMPL(a_two_shape, push && entry.two, entry.r0.len != 8'd0 && entry.r1.len == 8'd1)
  // a zero-length token is only the line-end token and closes the line
  `ASSERT_IMPL(a_empty_tok, m_axis_tvalid_o && m_axis_tdata_o[19:12] == 8'd0,
               m_axis_tdata_o[3:0] == K_LINE_END && m_axis_tlast_o)
  // nothing queued and nothing shown means nothing shown next cycle
  `ASSERT_NEXT(a_no_bypass, !qst.valid && !m_axis_tvalid_o, !m_axis_tvalid_o)

endmodule

`default_nettype wire

// ----- sv/alc_front.sv -----
// front part: accepts characters, tracks the word and line state, builds results
`default_nettype none

module alc_front import alc_pkg::*; #(
  parameter int MAX_LINE      = MAX_LINE_DEF,
  parameter int KEYWORD_CHARS = KEYWORD_CHARS_DEF
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   accept_i,
  input  wire logic [7:0] ch_i,
  input  wire logic   line_end_i,
  output entry_t      entry_o,
  output logic        push_o
);

  localparam int POS_CAP = (MAX_LINE - 1 < 255) ? MAX_LINE - 1 : 255;
  localparam int LEN_CAP = (MAX_LINE < 255) ? MAX_LINE : 255;
  localparam int HW      = 8 * KEYWORD_CHARS;

  logic [HW-1:0] word_head_q, word_head_d, wh_n;
  logic [7:0]    word_len_q, word_len_d, wl_n;
  logic [7:0]    word_start_q, word_start_d, ws_n;
  logic [7:0]    char_pos_q, char_pos_d;
  logic [3:0]    prev_kind_q, prev_kind_d;
  logic          line_has_q, line_has_d;

  logic          is_sep, is_punct, is_word, flush;
  logic [3:0]    punct_kind, word_kind;
  logic [4:0]    kw;
  res_t          res_word, res_punct, res_end;

  // character decode
  always_comb begin
    is_sep     = 1'b0;
    is_punct   = 1'b1;
    punct_kind = K_COMMA;
    case (ch_i)
      8'h20, 8'h09: begin
        is_sep   = 1'b1;
        is_punct = 1'b0;
      end
      8'h2c: punct_kind = K_COMMA;
      8'h3a: punct_kind = K_COLON;
      8'h5b: punct_kind = K_OPEN;
      8'h5d: punct_kind = K_CLOSE;
      8'h2b: punct_kind = K_PLUS;
      8'h2d: punct_kind = K_MINUS;
      8'h2a: punct_kind = K_MULT;
      default: is_punct = 1'b0;
    endcase
    is_word = !is_sep && !is_punct;
  end

  // pending word with this character added
  always_comb begin
    wh_n = word_head_q;
    wl_n = word_len_q;
    ws_n = word_start_q;
    if (is_word) begin
      if (word_len_q == 8'd0) begin
        ws_n = char_pos_q;
      end
      for (int i = 0; i < KEYWORD_CHARS; i++) begin
        if (word_len_q == 8'(i)) begin
          wh_n[8*i +: 8] = ch_i;
        end
      end
      if (word_len_q < 8'(LEN_CAP)) begin
        wl_n = word_len_q + 8'd1;
      end
    end
  end

  // word classification
  always_comb begin
    kw = kw_lookup(wh_n[8*KW_BYTES-1:0], wl_n);
    if (kw[4]) begin
      word_kind = kw[3:0];
    end else if (!line_has_q || prev_kind_q == K_PREFIX) begin
      word_kind = K_MNEMONIC;
    end else begin
      word_kind = K_UNKNOWN;
    end
  end

  // result assembly
  always_comb begin
    flush     = (!is_word || line_end_i) && (wl_n != 8'd0);
    res_word  = '{kind: word_kind, pos: ws_n, len: wl_n};
    res_punct = '{kind: punct_kind, pos: char_pos_q, len: 8'd1};
    res_end   = '{kind: K_LINE_END, pos: char_pos_q, len: 8'd0};
    entry_o.two  = flush && is_punct;
    entry_o.last = line_end_i;
    entry_o.r0   = flush ? res_word : (is_punct ? res_punct : res_end);
    entry_o.r1   = res_punct;
    push_o       = accept_i && (flush || is_punct || line_end_i);
  end

  // next line state
  always_comb begin
    word_head_d  = word_head_q;
    word_len_d   = word_len_q;
    word_start_d = word_start_q;
    char_pos_d   = char_pos_q;
    prev_kind_d  = prev_kind_q;
    line_has_d   = line_has_q;
    if (accept_i) begin
      if (line_end_i) begin
        word_head_d  = '0;
        word_len_d   = 8'd0;
        word_start_d = 8'd0;
        char_pos_d   = 8'd0;
        prev_kind_d  = K_UNKNOWN;
        line_has_d   = 1'b0;
      end else begin
        if (flush) begin
          word_head_d  = '0;
          word_len_d   = 8'd0;
          word_start_d = 8'd0;
        end else begin
          word_head_d  = wh_n;
          word_len_d   = wl_n;
          word_start_d = ws_n;
        end
        if (is_punct) begin
          prev_kind_d = punct_kind;
        end else if (flush) begin
          prev_kind_d = word_kind;
        end
        if (flush || is_punct) begin
          line_has_d = 1'b1;
        end
        if (char_pos_q < 8'(POS_CAP)) begin
          char_pos_d = char_pos_q + 8'd1;
        end
      end
    end
  end

  // line state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_head_q  <= '0;
      word_len_q   <= 8'd0;
      word_start_q <= 8'd0;
      char_pos_q   <= 8'd0;
      prev_kind_q  <= K_UNKNOWN;
      line_has_q   <= 1'b0;
    end else begin
      word_head_q  <= word_head_d;
      word_len_q   <= word_len_d;
      word_start_q <= word_start_d;
      char_pos_q   <= char_pos_d;
      prev_kind_q  <= prev_kind_d;
      line_has_q   <= line_has_d;
    end
  end

endmodule

`default_nettype wire

// ----- sv/alc_queue.sv -----
// short result queue between front and back
`default_nettype none

module alc_queue import alc_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  entry_t    entry_i,
  input  wire logic pop_i,
  output entry_t    head_o,
  output qstat_t    stat_o
);

  entry_t         mem_q [QDEPTH];
  logic [QAW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QAW:0]   cnt_q, cnt_d;
  logic           do_push, do_pop;

  // pointer and fill count update
  always_comb begin
    stat_o.full  = (cnt_q == (QAW+1)'(QDEPTH));
    stat_o.valid = (cnt_q != '0);
    do_push      = push_i && !stat_o.full;
    do_pop       = pop_i && stat_o.valid;
    wr_d         = do_push ? wr_q + 1'b1 : wr_q;
    rd_d         = do_pop ? rd_q + 1'b1 : rd_q;
    cnt_d        = cnt_q + (QAW+1)'(do_push) - (QAW+1)'(do_pop);
    head_o       = mem_q[rd_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= entry_i;
    end
  end

endmodule

`default_nettype wire

// ----- sv/alc_back.sv -----
// back part: splits queue entries into single results in an output register
`default_nettype none

module alc_back import alc_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  entry_t    head_i,
  input  wire logic head_valid_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output res_t      out_res_o,
  output logic      out_last_o
);

  logic ov_q, ov_d;
  logic phase_q, phase_d;
  logic load;
  res_t res_q, res_d;
  logic last_q, last_d;

  // take the next result when the output register frees
  always_comb begin
    load    = head_valid_i && (!ov_q || out_ready_i);
    ov_d    = ov_q;
    phase_d = phase_q;
    res_d   = res_q;
    last_d  = last_q;
    pop_o   = 1'b0;
    if (load) begin
      ov_d   = 1'b1;
      res_d  = phase_q ? head_i.r1 : head_i.r0;
      last_d = head_i.last && (phase_q || !head_i.two);
      if (head_i.two && !phase_q) begin
        phase_d = 1'b1;
      end else begin
        phase_d = 1'b0;
        pop_o   = 1'b1;
      end
    end else if (out_ready_i) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q    <= 1'b0;
      phase_q <= 1'b0;
    end else begin
      ov_q    <= ov_d;
      phase_q <= phase_d;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    res_q  <= res_d;
    last_q <= last_d;
  end

  assign out_valid_o = ov_q;
  assign out_res_o   = res_q;
  assign out_last_o  = last_q;

endmodule

`default_nettype wire

// ----- dv/asm_line_token_classifier_tb.sv -----
// self-checking testbench for the assembly line token classifier
`default_nettype none

module asm_line_token_classifier_tb import alc_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int POS_CAP   = (MAX_LINE_DEF - 1 < 255) ? MAX_LINE_DEF - 1 : 255;
  localparam int LEN_CAP   = (MAX_LINE_DEF < 255) ? MAX_LINE_DEF : 255;
  localparam int KEY_CHARS = KEYWORD_CHARS_DEF;
  localparam int NUM_KEYS  = 24;
  localparam int NUM_POOL  = 33;
  localparam int HOLD_LEN  = 120;
  localparam int SETTLE    = 8;
  localparam int PHASE_LEN = 255;

  // character codes with a meaning of their own
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_OPEN  = 8'h5b;
  localparam logic [7:0] CH_CLOSE = 8'h5d;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_MULT  = 8'h2a;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } char_item_t;

  typedef struct packed {
    logic [3:0] kind;
    logic [7:0] pos;
    logic [7:0] len;
    logic       last;
  } token_t;

  // exact-match keyword table of the lexer
  string      key_text [NUM_KEYS] = '{
    "fs", "ds", "gs", "es", "ss", "cs", "byte", "word", "dword", "qword",
    "eax", "ebx", "ecx", "edx", "ebp", "esp", "esi", "edi",
    "lock", "rep", "repne", "repe", "repz", "ptr"
  };
  logic [3:0] key_kind [NUM_KEYS] = '{
    K_SEGMENT, K_SEGMENT, K_SEGMENT, K_SEGMENT, K_SEGMENT, K_SEGMENT,
    K_MEMSIZE, K_MEMSIZE, K_MEMSIZE, K_MEMSIZE,
    K_REGISTER, K_REGISTER, K_REGISTER, K_REGISTER,
    K_REGISTER, K_REGISTER, K_REGISTER, K_REGISTER,
    K_PREFIX, K_PREFIX, K_PREFIX, K_PREFIX, K_PREFIX, K_PTR
  };

  // words for random lines: keywords, near misses and plain mnemonics
  string word_pool [NUM_POOL] = '{
    "fs", "ds", "gs", "es", "ss", "cs", "byte", "word", "dword", "qword",
    "eax", "ebx", "ecx", "edx", "ebp", "esp", "esi", "edi",
    "lock", "rep", "repne", "repe", "repz", "ptr",
    "mov", "add", "lea", "push", "eaxx", "re", "repn", "pt", "dwor"
  };
  logic [7:0] punct_pool [7] = '{
    CH_COMMA, CH_COLON, CH_OPEN, CH_CLOSE, CH_PLUS, CH_MINUS, CH_MULT
  };

  logic        clk_i    = 1'b0;
  logic        rst_ni   = 1'b0;
  logic        s_valid  = 1'b0;
  logic [7:0]  s_data   = '0;
  logic        s_last   = 1'b0;
  logic        m_ready  = 1'b0;
  logic        s_ready;
  logic        m_valid;
  logic [23:0] m_data;
  logic        m_last;

  asm_line_token_classifier u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tlast_i  (s_last),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tlast_o  (m_last)
  );

  // clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  char_item_t char_q [$];
  token_t     token_q [$];
  token_t     step_toks [$];

  int snd_idle_pct = 0;
  int rcv_stall_pct = 0;
  int hold_asks = 0;
  int hold_seen = 0;
  int hold_cnt = 0;
  int n_chars = 0;
  int n_lines = 0;
  int n_tokens = 0;
  int n_err = 0;

  // lexer state kept by the testbench
  logic [8*KEY_CHARS-1:0] word_head = '0;
  logic [7:0]             word_len = '0;
  logic [7:0]             word_start = '0;
  logic [7:0]             char_pos = '0;
  logic [3:0]             prev_kind = '0;
  logic                   line_has_token = 1'b0;

  function automatic logic [3:0] word_class();
    bit same;
    for (int i = 0; i < NUM_KEYS; i++) begin
      if (int'(word_len) == key_text[i].len()) begin
        same = 1'b1;
        for (int j = 0; j < key_text[i].len(); j++) begin
          if (word_head[8*j +: 8] != key_text[i][j]) same = 1'b0;
        end
        if (same) return key_kind[i];
      end
    end
    if (!line_has_token || prev_kind == K_PREFIX) return K_MNEMONIC;
    return K_UNKNOWN;
  endfunction

  function automatic void note_token(logic [3:0] kind, logic [7:0] pos, logic [7:0] len);
    token_t t;
    t = '{kind: kind, pos: pos, len: len, last: 1'b0};
    step_toks.insert(step_toks.size(), t);
    prev_kind = kind;
    line_has_token = 1'b1;
  endfunction

  function automatic void flush_word();
    if (word_len != 0) begin
      note_token(word_class(), word_start, word_len);
      word_head = '0;
      word_len = '0;
      word_start = '0;
    end
  endfunction

  // tokens caused by one accepted character
  function automatic void lex_char(char_item_t it);
    logic [3:0] pk;
    logic [7:0] pos;
    bit         is_sep;
    bit         is_punct;
    pos = char_pos;
    is_sep = (it.ch == CH_SPACE) || (it.ch == CH_TAB);
    is_punct = 1'b1;
    pk = K_UNKNOWN;
    step_toks.delete();
    case (it.ch)
      CH_COMMA: pk = K_COMMA;
      CH_COLON: pk = K_COLON;
      CH_OPEN:  pk = K_OPEN;
      CH_CLOSE: pk = K_CLOSE;
      CH_PLUS:  pk = K_PLUS;
      CH_MINUS: pk = K_MINUS;
      CH_MULT:  pk = K_MULT;
      default:  is_punct = 1'b0;
    endcase
    if (!is_sep && !is_punct) begin
      if (word_len == 0) word_start = pos;
      if (word_len < KEY_CHARS) word_head[8*word_len +: 8] = it.ch;
      if (word_len < LEN_CAP) word_len++;
    end else begin
      flush_word();
      if (is_punct) note_token(pk, pos, 8'd1);
    end
    if (char_pos < POS_CAP) char_pos++;
    if (it.last) begin
      flush_word();
      if (step_toks.size() == 0) note_token(K_LINE_END, pos, 8'd0);
      step_toks[step_toks.size()-1].last = 1'b1;
      word_head = '0;
      word_len = '0;
      word_start = '0;
      char_pos = '0;
      prev_kind = '0;
      line_has_token = 1'b0;
    end
    foreach (step_toks[i]) token_q.insert(token_q.size(), step_toks[i]);
  endfunction

  // driver: offer the next pending item, record accepted ones
  always @(posedge clk_i or negedge rst_ni) begin
    char_item_t nxt;
    if (!rst_ni) begin
      s_valid <= 1'b0;
      s_data <= '0;
      s_last <= 1'b0;
    end else begin
      if (s_valid && s_ready) begin
        lex_char('{ch: s_data, last: s_last});
        n_chars++;
        if (s_last) n_lines++;
      end
      if (!s_valid || s_ready) begin
        if (char_q.size() != 0 && $urandom_range(0, 99) >= snd_idle_pct) begin
          nxt = char_q.pop_front();
          s_valid <= 1'b1;
          s_data <= nxt.ch;
          s_last <= nxt.last;
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, counted here
  always @(posedge clk_i) begin
    if (hold_asks != hold_seen) begin
      hold_seen <= hold_asks;
      hold_cnt <= HOLD_LEN;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  // receiver ready
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_ready <= 1'b0;
    end else begin
      m_ready <= (hold_cnt == 0) && ($urandom_range(0, 99) >= rcv_stall_pct);
    end
  end

  // monitor: compare each token with the oldest expected one
  always @(posedge clk_i) begin
    token_t got;
    token_t want;
    if (rst_ni && m_valid && m_ready) begin
      got = '{kind: m_data[3:0], pos: m_data[11:4], len: m_data[19:12], last: m_last};
      n_tokens++;
      if (token_q.size() == 0) begin
        n_err++;
        $display("%t unexpected token kind %0d pos %0d len %0d last %0d", $realtime,
                 got.kind, got.pos, got.len, got.last);
      end else begin
        want = token_q.pop_front();
        if (got.kind != want.kind || got.pos != want.pos || got.len != want.len ||
            got.last != want.last) begin
          n_err++;
          $display("%t mismatch: expected kind/pos/len/last %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d",
                   $realtime, want.kind, want.pos, want.len, want.last,
                   got.kind, got.pos, got.len, got.last);
        end
      end
    end
  end

  task automatic push_text(string txt, bit ends_line);
    for (int i = 0; i < txt.len(); i++) begin
      char_q.insert(char_q.size(),
                    char_item_t'{ch: txt[i], last: ends_line && (i == txt.len() - 1)});
    end
  endtask

  // one random line, mostly well formed, sometimes plain noise
  task automatic gen_line(output int n);
    logic [7:0] line [$];
    int pieces;
    int r;
    string w;
    if ($urandom_range(0, 99) < 10) begin
      repeat ($urandom_range(1, 16)) line.insert(line.size(), 8'($urandom_range(0, 255)));
    end else begin
      pieces = $urandom_range(1, 10);
      for (int p = 0; p < pieces; p++) begin
        r = $urandom_range(0, 99);
        if (r < 35) begin
          w = word_pool[$urandom_range(0, NUM_POOL - 1)];
          for (int i = 0; i < w.len(); i++) line.insert(line.size(), w[i]);
          if ($urandom_range(0, 9) == 0) begin
            line.insert(line.size(), 8'($urandom_range(8'h61, 8'h7a)));
          end
        end else if (r < 50) begin
          repeat ($urandom_range(1, 9)) line.insert(line.size(), 8'($urandom_range(8'h61, 8'h7a)));
        end else if (r < 58) begin
          repeat ($urandom_range(1, 4)) line.insert(line.size(), 8'($urandom_range(0, 255)));
        end else if (r < 88) begin
          line.insert(line.size(), punct_pool[$urandom_range(0, 6)]);
        end else begin
          repeat ($urandom_range(1, 3)) begin
            line.insert(line.size(), $urandom_range(0, 1) ? CH_SPACE : CH_TAB);
          end
        end
        if ($urandom_range(0, 1)) line.insert(line.size(), CH_SPACE);
      end
    end
    foreach (line[i]) begin
      char_q.insert(char_q.size(), char_item_t'{ch: line[i], last: i == line.size() - 1});
    end
    n = line.size();
  endtask

  // one line past the position and length limits
  task automatic push_long_line();
    repeat (270) begin
      char_q.insert(char_q.size(),
                    char_item_t'{ch: 8'($urandom_range(8'h61, 8'h7a)), last: 1'b0});
    end
    push_text(" eax,q", 1'b1);
  endtask

  task automatic wait_drained();
    while (char_q.size() != 0 || s_valid || token_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic run_phase(int snd_pct, int rcv_pct, bit with_hold, bit with_long);
    int total;
    int n;
    total = 0;
    @(posedge clk_i);
    snd_idle_pct <= snd_pct;
    rcv_stall_pct <= rcv_pct;
    if (with_long) push_long_line();
    while (total < PHASE_LEN) begin
      gen_line(n);
      total += n;
    end
    if (with_hold) begin
      repeat (4) @(posedge clk_i);
      hold_asks <= hold_asks + 1;
    end
    wait_drained();
  endtask

  // stimulus sequence
  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: every token kind, line end on a word, a separator and punctuation
    push_text("lock x fs:[eax+y*z-1],ptr", 1'b1);
    push_text("byte\t", 1'b1);
    push_text(" ", 1'b1);
    push_text(",", 1'b1);
    char_q.insert(char_q.size(), char_item_t'{ch: 8'h00, last: 1'b0});
    char_q.insert(char_q.size(), char_item_t'{ch: 8'hff, last: 1'b1});
    wait_drained();

    run_phase(0, 0, 1'b1, 1'b0);
    run_phase(52, 0, 1'b0, 1'b1);
    run_phase(0, 52, 1'b1, 1'b0);
    run_phase(26, 26, 1'b0, 1'b1);
    run_phase(0, 0, 1'b0, 1'b0);

    $display("lexed %0d characters in %0d lines, %0d tokens checked,", n_chars, n_lines,
             n_tokens);
    $display("with sender gaps, receiver stalls, long hold-offs and saturated lines");
    if (n_err == 0) begin
      $display("[asm_line_token_classifier] OK");
    end else begin
      $display("[asm_line_token_classifier] ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("[asm_line_token_classifier] ERROR");
    $finish;
  end

endmodule

`default_nettype wire
